@@ hdl/sorted_deadline_timer_queue_assert.svh @@
// Assertion macros shared by the timer queue RTL.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SDTQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer queue assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SDTQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer queue assertion failed");

`endif

@@ hdl/sdtq_pkg.sv @@
// Shared codes and types of the sorted deadline timer queue.
package sdtq_pkg;

	// Fixed port widths.
	localparam int CMD_W     = 2;
	localparam int TIMEOUT_W = 24;
	localparam int HANDLE_W  = 4;
	localparam int KIND_W    = 2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSTALL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_EXPIRED   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSTALLED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FULL      = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVED   = 2'd3;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_INS,
		CELL_DEL
	} cell_op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRE,
		ST_INS_CMP,
		ST_INS_SHIFT,
		ST_REM,
		ST_DONE
	} state_t;

endpackage

@@ hdl/sorted_deadline_timer_queue.sv @@
// Top level of the sorted deadline timer queue.
`include "sorted_deadline_timer_queue_assert.svh"

// The queue keeps up to ENTRIES timers in a chain of cells, earliest deadline
// in cell 0, plus a wrapping tick counter of TIME_BITS. Deadlines compare by
// signed wrapping difference, so a timeout of more than half the counter
// range is seen as already past. Command 0 (tick) advances time by one and
// fires every due timer in deadline order, up to ENTRIES per tick, each as
// an "expired" word; the last word of the tick carries is_last. A tick with
// nothing due gives no word. Command 1 installs a timer on the lowest free
// handle with deadline now plus timeout (timeout masked to TIMEOUT_BITS);
// among equal deadlines the newer timer fires first. A periodic timer with a
// nonzero timeout is reinserted at its old deadline plus its period; with
// timeout zero it is one-shot. A full table answers "install failed" with
// handle 0. Command 2 removes a live handle and reports found; command 3 is
// dropped without a word. A command is taken only while the sequencer is
// idle. Install steps through a compare across all cells, a shift along the
// chain and a done step that registers the result word; remove through a
// removal step and the done step. A tick fires one due timer per fire step
// and reinserts a fired periodic timer by compare and shift. A result word
// that is not taken stalls the sequencer only when a further word is ready
// to be shown; the next command is accepted while the last word waits.
module sorted_deadline_timer_queue #(
	parameter int ENTRIES      = 16,
	parameter int TIME_BITS    = 32,
	parameter int TIMEOUT_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sdtq_pkg::CMD_W-1:0]     cmd,
	input  logic [sdtq_pkg::TIMEOUT_W-1:0] timeout,
	input  logic                           periodic,
	input  logic [sdtq_pkg::HANDLE_W-1:0]  handle,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sdtq_pkg::KIND_W-1:0]    kind,
	output logic [sdtq_pkg::HANDLE_W-1:0]  result_handle,
	output logic                           found,
	output logic                           is_last
);

	// Derived widths.
	localparam int TW   = TIME_BITS;
	localparam int RW   = (TIMEOUT_BITS < sdtq_pkg::TIMEOUT_W) ? TIMEOUT_BITS
		: sdtq_pkg::TIMEOUT_W;
	localparam int HW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int HX   = (HW > sdtq_pkg::HANDLE_W) ? HW : sdtq_pkg::HANDLE_W;
	localparam int SUMW = (TW > RW) ? TW : RW;
	localparam int FCW  = $clog2(ENTRIES + 1);

	// Sequencer and bookkeeping.
	sdtq_pkg::state_t st_q, st_d;
	logic [TW-1:0]      now_q, now_d;
	logic [ENTRIES-1:0] in_use_q, in_use_d;
	logic               tick_q, tick_d;
	logic [FCW-1:0]     fired_q, fired_d;

	// Timer waiting to be inserted into the chain.
	logic [TW-1:0] ins_dl_q, ins_dl_d;
	logic [RW-1:0] ins_rl_q, ins_rl_d;
	logic [HW-1:0] ins_h_q, ins_h_d;
	logic [sdtq_pkg::HANDLE_W-1:0] handle_q, handle_d;

	// Pending result word: its is_last is known only once the next step is.
	logic                          pend_v_q, pend_v_d;
	logic [sdtq_pkg::KIND_W-1:0]   pend_kind_q, pend_kind_d;
	logic [sdtq_pkg::HANDLE_W-1:0] pend_h_q, pend_h_d;
	logic                          pend_f_q, pend_f_d;

	// Output register.
	logic                          out_v_q, out_v_d;
	logic [sdtq_pkg::KIND_W-1:0]   out_kind_q, out_kind_d;
	logic [sdtq_pkg::HANDLE_W-1:0] out_h_q, out_h_d;
	logic                          out_f_q, out_f_d;
	logic                          out_last_q, out_last_d;

	// Chain wiring.
	sdtq_pkg::cell_op_t cell_op;
	logic [ENTRIES-1:0] del_mask;
	logic [ENTRIES-1:0] passed;
	logic [ENTRIES:0]   keep_inc;
	logic [ENTRIES-1:0] cell_keep;
	logic [ENTRIES-1:0] cell_v;
	logic [ENTRIES-1:0] cell_v_inc;
	logic [TW-1:0]      c_dl [ENTRIES];
	logic [RW-1:0]      c_rl [ENTRIES];
	logic [HW-1:0]      c_h  [ENTRIES];
	logic [TW-1:0]      p_dl [ENTRIES];
	logic [RW-1:0]      p_rl [ENTRIES];
	logic [HW-1:0]      p_h  [ENTRIES];
	logic [ENTRIES-1:0] p_v;
	logic [TW-1:0]      n_dl [ENTRIES];
	logic [RW-1:0]      n_rl [ENTRIES];
	logic [HW-1:0]      n_h  [ENTRIES];
	logic [ENTRIES-1:0] n_v;

	// Datapath helpers.
	logic [ENTRIES-1:0] free_oh;
	logic [HW-1:0]      free_h;
	logic               table_full;
	logic [RW-1:0]      to_eff;
	logic [TW-1:0]      install_dl;
	logic [TW-1:0]      reload_dl;
	logic [TW-1:0]      head_diff;
	logic               head_due;
	logic [ENTRIES-1:0] rem_match;
	logic [ENTRIES-1:0] rem_mask;
	logic               rem_found;
	logic [HX-1:0]      handle_x;
	logic [HX-1:0]      head_hx;
	logic [HX-1:0]      free_hx;

	genvar gi;
	generate
		for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				assign p_dl[gi] = '0;
				assign p_rl[gi] = '0;
				assign p_h[gi]  = '0;
				assign p_v[gi]  = 1'b0;
			end else begin : g_mid_prev
				assign p_dl[gi] = c_dl[gi-1];
				assign p_rl[gi] = c_rl[gi-1];
				assign p_h[gi]  = c_h[gi-1];
				assign p_v[gi]  = cell_v[gi-1];
			end
			if (gi == ENTRIES - 1) begin : g_last
				assign n_dl[gi] = '0;
				assign n_rl[gi] = '0;
				assign n_h[gi]  = '0;
				assign n_v[gi]  = 1'b0;
			end else begin : g_mid_next
				assign n_dl[gi] = c_dl[gi+1];
				assign n_rl[gi] = c_rl[gi+1];
				assign n_h[gi]  = c_h[gi+1];
				assign n_v[gi]  = cell_v[gi+1];
			end

			sdtq_cell #(
				.TW(TW),
				.RW(RW),
				.HW(HW)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.op      (cell_op),
				.passed  (passed[gi]),
				.del_here(del_mask[gi]),
				.ins_dl  (ins_dl_q),
				.ins_rl  (ins_rl_q),
				.ins_h   (ins_h_q),
				.prev_dl (p_dl[gi]),
				.prev_rl (p_rl[gi]),
				.prev_h  (p_h[gi]),
				.prev_v  (p_v[gi]),
				.next_dl (n_dl[gi]),
				.next_rl (n_rl[gi]),
				.next_h  (n_h[gi]),
				.next_v  (n_v[gi]),
				.dl      (c_dl[gi]),
				.rl      (c_rl[gi]),
				.h       (c_h[gi]),
				.v       (cell_v[gi]),
				.keep    (cell_keep[gi])
			);

			// Match for remove: a valid cell whose handle equals the request.
			assign rem_match[gi] = cell_v[gi] && (HX'(c_h[gi]) == handle_x);
		end
	endgenerate

	// Cells up to and including the first one not kept see the new timer
	// pass by; the first such cell takes it, later ones shift up.
	assign keep_inc = {1'b0, cell_keep} + (ENTRIES + 1)'(1);
	assign passed   = cell_keep ^ keep_inc[ENTRIES-1:0];

	// Remove drops the matching cell and pulls every later cell down.
	assign rem_mask  = ~(rem_match - ENTRIES'(1));
	assign rem_found = |rem_match;
	assign handle_x  = HX'(handle_q);

	// Lowest free handle.
	assign free_oh    = ~in_use_q & (in_use_q + ENTRIES'(1));
	assign table_full = &in_use_q;
	always_comb begin
		free_h = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (free_oh[i]) begin
				free_h = free_h | HW'(i);
			end
		end
	end

	// Deadline arithmetic.
	assign to_eff     = timeout[RW-1:0];
	assign install_dl = TW'(SUMW'(now_q) + SUMW'(to_eff));
	assign reload_dl  = TW'(SUMW'(c_dl[0]) + SUMW'(c_rl[0]));
	assign head_diff  = now_q - c_dl[0];
	assign head_due   = cell_v[0] && !head_diff[TW-1];
	assign head_hx    = HX'(c_h[0]);
	assign free_hx    = HX'(free_h);

	assign cell_v_inc = cell_v + ENTRIES'(1);

	assign in_ready = (st_q == sdtq_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= sdtq_pkg::ST_IDLE;
			now_q    <= '0;
			in_use_q <= '0;
			tick_q   <= 1'b0;
			fired_q  <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			st_q     <= st_d;
			now_q    <= now_d;
			in_use_q <= in_use_d;
			tick_q   <= tick_d;
			fired_q  <= fired_d;
			pend_v_q <= pend_v_d;
			out_v_q  <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		ins_dl_q    <= ins_dl_d;
		ins_rl_q    <= ins_rl_d;
		ins_h_q     <= ins_h_d;
		handle_q    <= handle_d;
		pend_kind_q <= pend_kind_d;
		pend_h_q    <= pend_h_d;
		pend_f_q    <= pend_f_d;
		out_kind_q  <= out_kind_d;
		out_h_q     <= out_h_d;
		out_f_q     <= out_f_d;
		out_last_q  <= out_last_d;
	end

	// Next state and chain control.
	always_comb begin
		st_d        = st_q;
		now_d       = now_q;
		in_use_d    = in_use_q;
		tick_d      = tick_q;
		fired_d     = fired_q;
		ins_dl_d    = ins_dl_q;
		ins_rl_d    = ins_rl_q;
		ins_h_d     = ins_h_q;
		handle_d    = handle_q;
		pend_v_d    = pend_v_q;
		pend_kind_d = pend_kind_q;
		pend_h_d    = pend_h_q;
		pend_f_d    = pend_f_q;
		out_v_d     = out_v_q && !out_ready;
		out_kind_d  = out_kind_q;
		out_h_d     = out_h_q;
		out_f_d     = out_f_q;
		out_last_d  = out_last_q;
		cell_op     = sdtq_pkg::CELL_HOLD;
		del_mask    = '0;

		unique case (st_q)
			sdtq_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (cmd)
						sdtq_pkg::CMD_TICK: begin
							now_d   = now_q + TW'(1);
							fired_d = '0;
							tick_d  = 1'b1;
							st_d    = sdtq_pkg::ST_FIRE;
						end
						sdtq_pkg::CMD_INSTALL: begin
							tick_d   = 1'b0;
							pend_v_d = 1'b1;
							pend_f_d = 1'b0;
							if (table_full) begin
								pend_kind_d = sdtq_pkg::KIND_FULL;
								pend_h_d    = '0;
								st_d        = sdtq_pkg::ST_DONE;
							end else begin
								in_use_d[free_h] = 1'b1;
								ins_dl_d    = install_dl;
								ins_rl_d    = periodic ? to_eff : '0;
								ins_h_d     = free_h;
								pend_kind_d = sdtq_pkg::KIND_INSTALLED;
								pend_h_d    = free_hx[sdtq_pkg::HANDLE_W-1:0];
								st_d        = sdtq_pkg::ST_INS_CMP;
							end
						end
						sdtq_pkg::CMD_REMOVE: begin
							handle_d = handle;
							tick_d   = 1'b0;
							st_d     = sdtq_pkg::ST_REM;
						end
						default: begin
							// Unused command: drop it.
						end
					endcase
				end
			end

			sdtq_pkg::ST_FIRE: begin
				// Hold while a pending word cannot move to the output register.
				if (!(pend_v_q && out_v_q)) begin
					if (head_due && (fired_q < FCW'(ENTRIES))) begin
						if (pend_v_q) begin
							out_v_d    = 1'b1;
							out_kind_d = pend_kind_q;
							out_h_d    = pend_h_q;
							out_f_d    = pend_f_q;
							out_last_d = 1'b0;
						end
						pend_v_d    = 1'b1;
						pend_kind_d = sdtq_pkg::KIND_EXPIRED;
						pend_h_d    = head_hx[sdtq_pkg::HANDLE_W-1:0];
						pend_f_d    = 1'b0;
						fired_d     = fired_q + FCW'(1);
						cell_op     = sdtq_pkg::CELL_DEL;
						del_mask    = '1;
						if (c_rl[0] != '0) begin
							ins_dl_d = reload_dl;
							ins_rl_d = c_rl[0];
							ins_h_d  = c_h[0];
							st_d     = sdtq_pkg::ST_INS_CMP;
						end else begin
							in_use_d[c_h[0]] = 1'b0;
						end
					end else begin
						if (pend_v_q) begin
							out_v_d    = 1'b1;
							out_kind_d = pend_kind_q;
							out_h_d    = pend_h_q;
							out_f_d    = pend_f_q;
							out_last_d = 1'b1;
						end
						pend_v_d = 1'b0;
						st_d     = sdtq_pkg::ST_IDLE;
					end
				end
			end

			sdtq_pkg::ST_INS_CMP: begin
				cell_op = sdtq_pkg::CELL_CMP;
				st_d    = sdtq_pkg::ST_INS_SHIFT;
			end

			sdtq_pkg::ST_INS_SHIFT: begin
				cell_op = sdtq_pkg::CELL_INS;
				st_d    = tick_q ? sdtq_pkg::ST_FIRE : sdtq_pkg::ST_DONE;
			end

			sdtq_pkg::ST_REM: begin
				if (rem_found) begin
					cell_op  = sdtq_pkg::CELL_DEL;
					del_mask = rem_mask;
					for (int i = 0; i < ENTRIES; i++) begin
						if (handle_x == HX'(i)) begin
							in_use_d[i] = 1'b0;
						end
					end
				end
				pend_v_d    = 1'b1;
				pend_kind_d = sdtq_pkg::KIND_REMOVED;
				pend_h_d    = handle_q;
				pend_f_d    = rem_found;
				st_d        = sdtq_pkg::ST_DONE;
			end

			sdtq_pkg::ST_DONE: begin
				if (!out_v_q) begin
					out_v_d    = 1'b1;
					out_kind_d = pend_kind_q;
					out_h_d    = pend_h_q;
					out_f_d    = pend_f_q;
					out_last_d = 1'b1;
					pend_v_d   = 1'b0;
					st_d       = sdtq_pkg::ST_IDLE;
				end
			end

			default: begin
				st_d = sdtq_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid     = out_v_q;
	assign kind          = out_kind_q;
	assign result_handle = out_h_q;
	assign found         = out_f_q;
	assign is_last       = out_last_q;

	// No word may be left behind when a new command can be taken.
	`SDTQ_ASSERT_IMPL(a_idle_no_pending, st_q == sdtq_pkg::ST_IDLE, !pend_v_q)
	// Valid cells always form an unbroken run from cell 0.
	`SDTQ_ASSERT_IMPL(a_cells_packed, 1'b1, (cell_v & cell_v_inc) == '0)
	// Between commands the number of valid cells matches the number of live handles.
	`SDTQ_ASSERT_IMPL(a_cells_track_handles, st_q == sdtq_pkg::ST_IDLE,
		$countones(cell_v) == $countones(in_use_q))
	// One tick never fires more than the table holds.
	`SDTQ_ASSERT_IMPL(a_fire_bound, 1'b1, fired_q <= FCW'(ENTRIES))
	// Closing a command always shows its last word next cycle.
	`SDTQ_ASSERT_NEXT(a_done_shows_last, (st_q == sdtq_pkg::ST_DONE) && !out_v_q,
		out_v_q && out_last_q)

endmodule

@@ hdl/sdtq_cell.sv @@
// One cell of the sorted timer chain: holds one timer and shifts with its neighbors.
module sdtq_cell #(
	parameter int TW = 32,
	parameter int RW = 24,
	parameter int HW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sdtq_pkg::cell_op_t op,
	input  logic              passed,
	input  logic              del_here,
	input  logic [TW-1:0]     ins_dl,
	input  logic [RW-1:0]     ins_rl,
	input  logic [HW-1:0]     ins_h,
	input  logic [TW-1:0]     prev_dl,
	input  logic [RW-1:0]     prev_rl,
	input  logic [HW-1:0]     prev_h,
	input  logic              prev_v,
	input  logic [TW-1:0]     next_dl,
	input  logic [RW-1:0]     next_rl,
	input  logic [HW-1:0]     next_h,
	input  logic              next_v,
	output logic [TW-1:0]     dl,
	output logic [RW-1:0]     rl,
	output logic [HW-1:0]     h,
	output logic              v,
	output logic              keep
);

	logic [TW-1:0] dl_q, dl_d;
	logic [RW-1:0] rl_q, rl_d;
	logic [HW-1:0] h_q, h_d;
	logic          v_q, v_d;
	logic          keep_q, keep_d;
	logic [TW-1:0] diff;

	// Keep this cell in place when it is strictly earlier than the new deadline.
	always_comb begin
		diff   = ins_dl - dl_q;
		keep_d = keep_q;
		dl_d   = dl_q;
		rl_d   = rl_q;
		h_d    = h_q;
		v_d    = v_q;
		unique case (op)
			sdtq_pkg::CELL_HOLD: begin
			end
			sdtq_pkg::CELL_CMP: begin
				keep_d = v_q && (diff != '0) && !diff[TW-1];
			end
			sdtq_pkg::CELL_INS: begin
				if (!passed) begin
					dl_d = prev_dl;
					rl_d = prev_rl;
					h_d  = prev_h;
					v_d  = prev_v;
				end else if (!keep_q) begin
					dl_d = ins_dl;
					rl_d = ins_rl;
					h_d  = ins_h;
					v_d  = 1'b1;
				end
			end
			sdtq_pkg::CELL_DEL: begin
				if (del_here) begin
					dl_d = next_dl;
					rl_d = next_rl;
					h_d  = next_h;
					v_d  = next_v;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		dl_q   <= dl_d;
		rl_q   <= rl_d;
		h_q    <= h_d;
		keep_q <= keep_d;
	end

	assign dl   = dl_q;
	assign rl   = rl_q;
	assign h    = h_q;
	assign v    = v_q;
	assign keep = keep_q;

endmodule
